// ===== hdl/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// rth_pkg
// Shared constants, types and the divider step for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

  localparam int COMP_BITS     = 8;
  localparam int HUE_FRAC_BITS = 4;
  localparam int HUE_W         = 13;

  // One 60 degree sector in hue units.
  localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL   = 6 * HUE_SECTOR;
  localparam int SAT_SCALE  = (1 << COMP_BITS) - 1;

  // Quotient bits per divider. The hue quotient reaches one full sector,
  // and the saturation quotient needs COMP_BITS.
  localparam int HUE_Q_BITS = $clog2(HUE_SECTOR + 1);
  localparam int DIV_STEPS  = (HUE_Q_BITS > COMP_BITS) ? HUE_Q_BITS : COMP_BITS;
  localparam int DIV_W      = COMP_BITS + DIV_STEPS;
  localparam int HCALC_W    = $clog2(HUE_FULL);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } rth_sector_t;

  // Classified pixel, front to back.
  typedef struct packed {
    logic [COMP_BITS-1:0] vmax;
    logic [COMP_BITS-1:0] delta;
    rth_sector_t          sector;
    logic                 neg;
    logic [COMP_BITS-1:0] adiff;
  } rth_item_t;

  // One stage of the divider pipeline. Each divider word is
  // {partial remainder, numerator bits still to consume / quotient bits}.
  typedef struct packed {
    logic [COMP_BITS-1:0] vmax;
    logic [COMP_BITS-1:0] delta;
    rth_sector_t          sector;
    logic                 neg;
    logic [DIV_W-1:0]     sat_w;
    logic [DIV_W-1:0]     hue_w;
  } rth_stage_t;

  // One restoring division step: shift in the next numerator bit, subtract
  // when it fits, shift the quotient bit into the low end.
  function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] word,
                                                input logic [COMP_BITS-1:0] divisor);
    logic [COMP_BITS:0] t;
    logic               q;
    t = word[DIV_W-1:DIV_STEPS-1];
    q = (t >= {1'b0, divisor});
    if (q) begin
      t = t - {1'b0, divisor};
    end
    return {t[COMP_BITS-1:0], word[DIV_STEPS-2:0], q};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rth_front.sv =====
// ----------------------------------------------------------------------------
// rth_front
// Accepts pixels and classifies them: max, min spread, max channel, signed
// difference of the other two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_front
  import rth_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [COMP_BITS-1:0] red,
  input  wire logic [COMP_BITS-1:0] green,
  input  wire logic [COMP_BITS-1:0] blue,
  output logic                      q_push,
  input  wire logic                 q_full,
  output rth_item_t                 q_item
);

  logic       item_valid;
  rth_item_t  item;
  rth_item_t  item_next;
  logic       load;

  logic [COMP_BITS-1:0] vmin;
  logic [COMP_BITS:0]   diff;

  always_comb begin
    item_next = '0;
    if (red >= green && red >= blue) begin
      item_next.sector = SEC_RED;
      item_next.vmax   = red;
      diff             = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      item_next.sector = SEC_GREEN;
      item_next.vmax   = green;
      diff             = {1'b0, blue} - {1'b0, red};
    end else begin
      item_next.sector = SEC_BLUE;
      item_next.vmax   = blue;
      diff             = {1'b0, red} - {1'b0, green};
    end
    vmin = red;
    if (green < vmin) vmin = green;
    if (blue < vmin) vmin = blue;
    item_next.delta = item_next.vmax - vmin;
    item_next.neg   = diff[COMP_BITS];
    item_next.adiff = diff[COMP_BITS] ? COMP_BITS'(-diff) : diff[COMP_BITS-1:0];
  end

  assign full   = item_valid && q_full;
  assign load   = !full;
  assign q_push = item_valid && !q_full;
  assign q_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rth_queue.sv =====
// ----------------------------------------------------------------------------
// rth_queue
// Small FIFO of classified pixels between the front and the divider pipe.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_queue
  import rth_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire rth_item_t wr_item,
  input  wire logic      pop,
  output logic           empty,
  output rth_item_t      rd_item
);

  rth_item_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("front pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/rth_back.sv =====
// ----------------------------------------------------------------------------
// rth_back
// Divider pipeline: one restoring step per stage for saturation and hue,
// then hue offset and wrap into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rth_back
  import rth_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire rth_item_t            q_item,
  output logic                      q_pop,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [HUE_W-1:0]          hue,
  output logic [COMP_BITS-1:0]      saturation,
  output logic [COMP_BITS-1:0]      brightness
);

  rth_stage_t            stg   [DIV_STEPS+1];
  logic [DIV_STEPS:0]    stg_valid;
  rth_stage_t            load;
  logic                  adv;
  logic                  out_valid;

  logic [HUE_W-1:0]      hue_next;
  logic [COMP_BITS-1:0]  sat_next;
  logic [DIV_STEPS-1:0]  hq;
  logic [HCALC_W-1:0]    hoff;
  logic [HCALC_W-1:0]    hceil;

  // Whole pipe moves when the output register is free or being drained.
  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  always_comb begin
    load        = '0;
    load.vmax   = q_item.vmax;
    load.delta  = q_item.delta;
    load.sector = q_item.sector;
    load.neg    = q_item.neg;
    load.sat_w  = DIV_W'(q_item.delta) * DIV_W'(SAT_SCALE);
    load.hue_w  = DIV_W'(q_item.adiff) * DIV_W'(HUE_SECTOR);
  end

  // Final stage: floor for negative differences, sector offset, wrap; hue 0 for gray, saturation 0 for black.
  always_comb begin
    hq = stg[DIV_STEPS].hue_w[DIV_STEPS-1:0];
    unique case (stg[DIV_STEPS].sector)
      SEC_RED:   hoff = '0;
      SEC_GREEN: hoff = HCALC_W'(2 * HUE_SECTOR);
      SEC_BLUE:  hoff = HCALC_W'(4 * HUE_SECTOR);
      default:   hoff = '0;
    endcase
    hceil = HCALC_W'(hq);
    if (stg[DIV_STEPS].neg) begin
      if (stg[DIV_STEPS].hue_w[DIV_W-1:DIV_STEPS] != '0) hceil = hceil + 1'b1;
      if (hoff >= hceil) begin
        hue_next = HUE_W'(hoff - hceil);
      end else begin
        hue_next = HUE_W'(hoff + HCALC_W'(HUE_FULL) - hceil);
      end
    end else begin
      hue_next = HUE_W'(hoff + hceil);
    end
    if (stg[DIV_STEPS].delta == '0) hue_next = '0;
    sat_next = stg[DIV_STEPS].sat_w[COMP_BITS-1:0];
    if (stg[DIV_STEPS].vmax == '0) sat_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      stg_valid <= {stg_valid[DIV_STEPS-1:0], !q_empty};
      out_valid <= stg_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= load;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        stg[k].vmax   <= stg[k-1].vmax;
        stg[k].delta  <= stg[k-1].delta;
        stg[k].sector <= stg[k-1].sector;
        stg[k].neg    <= stg[k-1].neg;
        stg[k].sat_w  <= div_step(stg[k-1].sat_w, stg[k-1].vmax);
        stg[k].hue_w  <= div_step(stg[k-1].hue_w, stg[k-1].delta);
      end
      hue        <= hue_next;
      saturation <= sat_next;
      brightness <= stg[DIV_STEPS].vmax;
    end
  end

`ifndef ASSERT_OFF
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hue < HUE_W'(HUE_FULL)))
    else $error("hue out of range");

  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && brightness == '0) |-> (saturation == '0 && hue == '0))
    else $error("black pixel with nonzero saturation or hue");
`endif

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB to HSV pixel converter, one pixel per clock while the output is drained.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive red/green/blue and raise push; a beat is taken on a
//   clock edge with push high and full low.
//   Output channel: while empty is low, hue/saturation/brightness hold the
//   oldest result; raise pop to take that beat.
//   Components are 8 bits and hue is in sixteenth-degree units. Throughput
//   is one pixel per clock while the receiver keeps pop high, set by the
//   divider pipe doing one quotient bit per stage.
//   Front register classifies the pixel, a 4-deep queue decouples it from
//   the divider pipe, which ends in the output register.
//   Receiver stall: the divider pipe holds while the output beat waits,
//   the queue fills, then full rises; no beat is lost.
//   Reset (rst, synchronous): all valid bits and queue pointers clear; full
//   and empty settle to 0 and 1 on the next edge. No clearing pass.
//   Hue is in sixteenths of a degree, 0 for gray; saturation is 0 for black.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter
  import rth_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [COMP_BITS-1:0] red,
  input  wire logic [COMP_BITS-1:0] green,
  input  wire logic [COMP_BITS-1:0] blue,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [HUE_W-1:0]          hue,
  output logic [COMP_BITS-1:0]      saturation,
  output logic [COMP_BITS-1:0]      brightness
);

  // front -> queue
  logic      fq_push;
  logic      fq_full;
  rth_item_t fq_item;

  // queue -> back
  logic      qb_pop;
  logic      qb_empty;
  rth_item_t qb_item;

  rth_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .red    (red),
    .green  (green),
    .blue   (blue),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_item (fq_item)
  );

  rth_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .full    (fq_full),
    .wr_item (fq_item),
    .pop     (qb_pop),
    .empty   (qb_empty),
    .rd_item (qb_item)
  );

  rth_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (qb_empty),
    .q_item     (qb_item),
    .q_pop      (qb_pop),
    .pop        (pop),
    .empty      (empty),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule

`default_nettype wire
